FILE: hw/rtl/wtsp_pkg.sv
// Package: shared constants, codes and item types of the point projector.
`timescale 1ns / 1ps
package wtsp_pkg;

    // Field widths
    localparam int COEF_W    = 32;
    localparam int IDX_W     = 4;
    localparam int PIX_W     = 16;
    localparam int SCALE_W   = 14;
    localparam int COEF_NUM  = 16;

    // Datapath widths
    localparam int FPROD_W   = 48;                  // floored Q16.16 product
    localparam int ACC_W     = 50;                  // clip coordinate
    localparam int NUM_W     = 51;                  // numerator and denominator
    localparam int PROD_W    = NUM_W + SCALE_W;     // scaled numerator
    localparam int QUO_W     = 17;                  // quotient incl. overflow bit
    localparam int DSH_W     = NUM_W + QUO_W - 1;   // shifted denominator
    localparam int LANES     = 2;                   // x and y
    localparam int ROWS      = 3;                   // matrix rows 0, 1 and 3

    // Smallest clip w (Q16.16) with 10 * w >= 1.0
    localparam logic signed [ACC_W-1:0] VIS_MIN = ACC_W'(6554);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    // Item functions
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [COEF_W-1:0] point_x;
        logic signed [COEF_W-1:0] point_y;
        logic signed [COEF_W-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic                    visible;
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
    } t_out_item;

endpackage

FILE: hw/rtl/wtsp_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface wtsp_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/world_to_screen_projector.sv
// Top level: pipelined perspective projection and viewport mapping.
//
//  Channel    Dir  Payload                                      Transfer
//  i_item     in   func, coef_index, coef_value, point_x/y/z    valid & ready
//  o_result   out  visible, pixel_x, pixel_y                    valid & ready
//  i_cfg_*    in   register index, 14-bit data                  i_cfg_we
//
//  One item enters per cycle unless the output stalls; a point passes stages 1-4,
//  a 17-step restoring divider (one quotient bit per stage) and the output register.
//  Load items update the matrix at their transfer and give no result.
//  All stages advance together; a stall at the output freezes the whole pipeline.
//  Synchronous reset clears the matrix, the viewport registers and all valid bits.
`timescale 1ns / 1ps
module world_to_screen_projector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    wtsp_stream_if.sink                          i_item,
    wtsp_stream_if.source                        o_result,
    input  logic                                 i_cfg_we,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wtsp_pkg::SCALE_W-1:0]         i_cfg_data
);
    import wtsp_pkg::*;

    // Matrix and viewport
    logic signed [COEF_W-1:0]  r_mat [COEF_NUM];
    logic [SCALE_W-1:0]        r_width;
    logic [SCALE_W-1:0]        r_height;

    // Stage 1: floored products and translations
    logic                      r_s1_vld;
    logic signed [FPROD_W-1:0] r_s1_prod [ROWS][3];
    logic signed [COEF_W-1:0]  r_s1_trans [ROWS];
    // Stage 2: clip coordinates
    logic                      r_s2_vld;
    logic signed [ACC_W-1:0]   r_s2_acc [ROWS];
    // Stage 3: visibility, magnitudes, denominator
    logic                      r_s3_vld;
    logic                      r_s3_vis;
    logic                      r_s3_neg [LANES];
    logic [NUM_W-1:0]          r_s3_mag [LANES];
    logic [NUM_W-1:0]          r_s3_den;
    // Stage 4: scaled numerators
    logic                      r_s4_vld;
    logic                      r_s4_vis;
    logic                      r_s4_neg [LANES];
    logic [PROD_W-1:0]         r_s4_num [LANES];
    logic [NUM_W-1:0]          r_s4_den;
    // Divider stages
    logic                      r_dv_vld [QUO_W];
    logic                      r_dv_vis [QUO_W];
    logic                      r_dv_neg [QUO_W][LANES];
    logic [PROD_W-1:0]         r_dv_rem [QUO_W][LANES];
    logic [QUO_W-1:0]          r_dv_quo [QUO_W][LANES];
    logic [NUM_W-1:0]          r_dv_den [QUO_W];
    // Output register
    logic                      r_out_vld;
    t_out_item                 r_out;

    logic                      w_en;
    logic                      w_take;
    logic signed [2*COEF_W-1:0] w_prod [ROWS][3];
    logic signed [ACC_W-1:0]   w_acc [ROWS];
    logic signed [NUM_W-1:0]   w_num [LANES];
    logic [PROD_W-1:0]         n_rem [QUO_W][LANES];
    logic [QUO_W-1:0]          n_quo [QUO_W][LANES];
    logic signed [PIX_W-1:0]   w_pix [LANES];

    // Advance whenever the output register is free or being taken
    assign w_en           = !r_out_vld || o_result.ready;
    assign i_item.ready   = w_en;
    assign w_take         = i_item.valid && w_en;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    // Hold viewport registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Write one coefficient per load transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEF_NUM; i++) r_mat[i] <= '0;
        end else if (w_take && i_item.data.func == FUNC_LOAD) begin
            r_mat[i_item.data.coef_index] <= i_item.data.coef_value;
        end
    end

    // Form products of the point with rows 0, 1 and 3
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_prod[r][0] = i_item.data.point_x * r_mat[(r == 2) ? 12 : r * 4];
            w_prod[r][1] = i_item.data.point_y * r_mat[((r == 2) ? 12 : r * 4) + 1];
            w_prod[r][2] = i_item.data.point_z * r_mat[((r == 2) ? 12 : r * 4) + 2];
        end
    end

    // Sum floored products with translation
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_acc[r] = ACC_W'(r_s1_prod[r][0]) + ACC_W'(r_s1_prod[r][1])
                     + ACC_W'(r_s1_prod[r][2]) + ACC_W'(r_s1_trans[r]);
        end
    end

    // Viewport numerators: x + w and w - y
    assign w_num[0] = NUM_W'(r_s2_acc[0]) + NUM_W'(r_s2_acc[2]);
    assign w_num[1] = NUM_W'(r_s2_acc[2]) - NUM_W'(r_s2_acc[1]);

    // Restoring division, one quotient bit per stage
    always_comb begin
        logic [PROD_W-1:0] src_rem;
        logic [QUO_W-1:0]  src_quo;
        logic [NUM_W-1:0]  src_den;
        logic [DSH_W-1:0]  dsh;
        logic [DSH_W-1:0]  rext;
        logic              ge;
        for (int k = 0; k < QUO_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                src_rem = (k == 0) ? r_s4_num[l] : r_dv_rem[(k == 0) ? 0 : k - 1][l];
                src_quo = (k == 0) ? '0 : r_dv_quo[(k == 0) ? 0 : k - 1][l];
                src_den = (k == 0) ? r_s4_den : r_dv_den[(k == 0) ? 0 : k - 1];
                dsh     = DSH_W'(src_den) << (QUO_W - 1 - k);
                rext    = DSH_W'(src_rem);
                ge      = rext >= dsh;
                n_rem[k][l] = ge ? PROD_W'(rext - dsh) : src_rem;
                n_quo[k][l] = {src_quo[QUO_W-2:0], ge};
            end
        end
    end

    // Saturate and sign the quotients
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_dv_neg[QUO_W-1][l]) begin
                w_pix[l] = (r_dv_quo[QUO_W-1][l] > QUO_W'(32768)) ? PIX_W'(-32768)
                         : PIX_W'(-r_dv_quo[QUO_W-1][l]);
            end else begin
                w_pix[l] = (r_dv_quo[QUO_W-1][l] > QUO_W'(32767)) ? PIX_W'(32767)
                         : PIX_W'(r_dv_quo[QUO_W-1][l]);
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            for (int k = 0; k < QUO_W; k++) r_dv_vld[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= w_take && i_item.data.func == FUNC_POINT;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_dv_vld[0] <= r_s4_vld;
            for (int k = 1; k < QUO_W; k++) r_dv_vld[k] <= r_dv_vld[k-1];
            r_out_vld <= r_dv_vld[QUO_W-1];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < 3; c++) r_s1_prod[r][c] <= w_prod[r][c][2*COEF_W-1:16];
                r_s1_trans[r] <= r_mat[((r == 2) ? 12 : r * 4) + 3];
                r_s2_acc[r]   <= w_acc[r];
            end
            r_s3_vis <= r_s2_acc[2] >= VIS_MIN;
            r_s3_den <= {r_s2_acc[2][ACC_W-1:0], 1'b0};
            for (int l = 0; l < LANES; l++) begin
                r_s3_neg[l] <= w_num[l][NUM_W-1];
                r_s3_mag[l] <= w_num[l][NUM_W-1] ? NUM_W'(-w_num[l]) : NUM_W'(w_num[l]);
                r_s4_neg[l] <= r_s3_neg[l];
                r_s4_num[l] <= PROD_W'(r_s3_mag[l])
                             * PROD_W'((l == 0) ? r_width : r_height);
            end
            r_s4_vis <= r_s3_vis;
            r_s4_den <= r_s3_den;
            for (int k = 0; k < QUO_W; k++) begin
                r_dv_vis[k] <= (k == 0) ? r_s4_vis : r_dv_vis[(k == 0) ? 0 : k - 1];
                r_dv_den[k] <= (k == 0) ? r_s4_den : r_dv_den[(k == 0) ? 0 : k - 1];
                for (int l = 0; l < LANES; l++) begin
                    r_dv_neg[k][l] <= (k == 0) ? r_s4_neg[l]
                                    : r_dv_neg[(k == 0) ? 0 : k - 1][l];
                    r_dv_rem[k][l] <= n_rem[k][l];
                    r_dv_quo[k][l] <= n_quo[k][l];
                end
            end
            r_out.visible <= r_dv_vis[QUO_W-1];
            r_out.pixel_x <= r_dv_vis[QUO_W-1] ? w_pix[0] : '0;
            r_out.pixel_y <= r_dv_vis[QUO_W-1] ? w_pix[1] : '0;
        end
    end

`ifndef SYNTH
    // A hidden point reports the origin
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.visible) |-> (r_out.pixel_x == 0 && r_out.pixel_y == 0))
        else $error("hidden point with nonzero pixel");

    // A load transfer never enters the pipeline
    a_load_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.data.func == FUNC_LOAD) |=> !r_s1_vld)
        else $error("load item entered pipeline");

    // A load transfer lands in the addressed coefficient
    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.data.func == FUNC_LOAD)
        |=> r_mat[$past(i_item.data.coef_index)] == $past(i_item.data.coef_value))
        else $error("coefficient not written");

    // A stall freezes the divider tail
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_dv_vld[QUO_W-1]) && $stable(r_out)))
        else $error("pipeline moved during stall");
`endif

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives coefficient loads and points through the projector and checks results.
`timescale 1ns / 1ps
module tb_top;
    import wtsp_pkg::*;

    localparam int PIPE_DRAIN  = 30;      // margin over the pipeline's result latency
    localparam int LONG_HOLD   = 300;     // receiver hold-off that backs up the pipeline
    localparam int STALL_LIMIT = 3000;    // cycles with no transfer before giving up
    localparam int RAND_ITEMS  = 55;      // random items per viewport setting

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SCALE_W-1:0]   i_cfg_data;

    wtsp_stream_if #(.t_data(t_in_item))  item_ch ();
    wtsp_stream_if #(.t_data(t_out_item)) result_ch ();

    world_to_screen_projector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch.sink),
        .o_result    (result_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Mirror of the block state
    longint      coef_mirror [COEF_NUM];
    longint      view_width;
    longint      view_height;
    t_out_item   pixels_due [$];
    int          err_count;
    bit          quiet;       // no idling on either side
    bit          hold_req;    // ask the receiver for a long hold-off

    // Clock
    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // floor(a * b / 2^16)
    function automatic longint mul_q16(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint clip_row(int row, longint px, longint py, longint pz);
        return mul_q16(px, coef_mirror[row*4]) + mul_q16(py, coef_mirror[row*4+1])
             + mul_q16(pz, coef_mirror[row*4+2]) + coef_mirror[row*4+3];
    endfunction

    // trunc(scale * num / den), saturated to 16 bits
    function automatic logic signed [PIX_W-1:0] viewport_map(longint scale, longint num,
                                                              longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag * longint'(scale)) / longint'(den);
        if (num < 0)
            return (q > 32768) ? 16'sh8000 : PIX_W'(-longint'(q));
        return (q > 32767) ? 16'sd32767 : PIX_W'(q);
    endfunction

    // Apply one accepted item to the mirror and queue the pixels it yields
    task automatic predict_item(t_in_item it);
        longint cx;
        longint cy;
        longint cw;
        t_out_item r;
        if (it.func == FUNC_LOAD) begin
            coef_mirror[it.coef_index] = longint'(it.coef_value);
            return;
        end
        cx = clip_row(0, it.point_x, it.point_y, it.point_z);
        cy = clip_row(1, it.point_x, it.point_y, it.point_z);
        cw = clip_row(3, it.point_x, it.point_y, it.point_z);
        r = '0;
        if (cw * 10 >= 65536) begin
            r.visible = 1'b1;
            r.pixel_x = viewport_map(view_width, cx + cw, 2 * cw);
            r.pixel_y = viewport_map(view_height, cw - cy, 2 * cw);
        end
        pixels_due.push_back(r);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Offer one item and hold it until transfer
    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic load_coef(int idx, longint val);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.func       = FUNC_LOAD;
        it.coef_index = IDX_W'(idx);
        it.coef_value = COEF_W'(val);
        send_item(it);
    endtask

    task automatic send_point(longint x, longint y, longint z);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom});
        it.func    = FUNC_POINT;
        it.point_x = COEF_W'(x);
        it.point_y = COEF_W'(y);
        it.point_z = COEF_W'(z);
        send_item(it);
    endtask

    // Drop valid, let every result come out, then let trailing loads settle
    task automatic drain_pipe();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= SCALE_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_SCREEN_WIDTH)
            view_width = val & 16'h3FFF;
        else
            view_height = val & 16'h3FFF;
    endtask

    task automatic set_viewport(int w, int h);
        drain_pipe();
        write_cfg(CFG_SCREEN_WIDTH, w);
        write_cfg(CFG_SCREEN_HEIGHT, h);
    endtask

    // Identity-style projection: clip w = z + 1.0
    task automatic load_camera();
        for (int i = 0; i < COEF_NUM; i++)
            load_coef(i, (i == 0 || i == 5 || i == 10 || i == 14 || i == 15) ? 65536 : 0);
    endtask

    // Zero matrix after reset: every point is behind the camera
    task automatic test_reset_matrix();
        send_point(0, 0, 0);
        send_point(32'h7FFFFFFF, -32'sh80000000, 32'h12345678);
    endtask

    task automatic test_extremes();
        set_viewport(640, 480);
        load_camera();
        send_point(0, 0, 0);                                 // screen center
        send_point(65536, 65536, 0);                         // corner
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0);           // far off, saturates
        send_point(-32'sh80000000, -32'sh80000000, 0);
        send_point(32'h7FFFFFFF, -32'sh80000000, 32'h7FFFFFFF);
        send_point(0, 0, -32'sh80000000);                    // behind the camera
        set_viewport(16383, 16383);
        send_point(32'h7FFFFFFF, -32'sh80000000, 0);
        send_point(-65536, 65536, 65536);
        set_viewport(0, 0);                                  // empty viewport
        send_point(12345, -54321, 0);
    endtask

    // Clip w straddling the visibility threshold
    task automatic test_threshold();
        set_viewport(1000, 1000);
        load_coef(14, 0);
        load_coef(15, 6553);
        send_point(0, 0, 0);
        load_coef(15, 6554);
        send_point(0, 0, 0);
        send_point(100, -100, 0);
        load_coef(15, 65536);
        load_coef(14, 32'h7FFFFFFF);
        load_coef(3, -32'sh80000000);
        send_point(65536, 65536, 65536);
    endtask

    function automatic longint rand_small();
        return longint'($signed($urandom_range(0, 32'h0003FFFF))) - 32'h0001FFFF;
    endfunction

    task automatic random_phase(int w, int h, bit press);
        set_viewport(w, h);
        load_camera();
        for (int i = 0; i < 4; i++) begin
            load_coef(i, rand_small() <<< 1);
            load_coef(4 + i, rand_small() <<< 1);
        end
        if (press)
            hold_req = 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ($urandom_range(0, 19))
                0: load_coef($urandom_range(0, 15), longint'($signed($urandom)));
                1, 2: load_coef($urandom_range(0, 11), rand_small());
                3: send_point(longint'($signed($urandom)), longint'($signed($urandom)),
                              longint'($signed($urandom)));
                default: send_point(rand_small() <<< 2, rand_small() <<< 2,
                                    longint'($urandom_range(0, 32'h00200000)));
            endcase
        end
        // restore a sane w row if noise broke it
        load_coef(12, 0);
        load_coef(13, 0);
        load_coef(14, 65536);
        load_coef(15, 65536);
    endtask

    // Receiver: random stalls plus one long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pixels_due.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pixels_due.pop_front();
                if (result_ch.data.visible !== want.visible)
                    report_mismatch("visible", result_ch.data.visible, want.visible);
                if (result_ch.data.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", result_ch.data.pixel_x, want.pixel_x);
                if (result_ch.data.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", result_ch.data.pixel_y, want.pixel_y);
            end
        end
    end

    // Watchdog: count cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** world_to_screen_projector: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        err_count     = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        view_width    = 0;
        view_height   = 0;
        foreach (coef_mirror[i]) coef_mirror[i] = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_matrix();
        test_extremes();
        test_threshold();
        random_phase(16383, 16383, 1'b1);
        random_phase(0, 0, 1'b0);
        random_phase($urandom_range(1, 16382), $urandom_range(1, 16382), 1'b0);
        random_phase(1, 1, 1'b0);
        quiet = 1'b1;
        random_phase(1920, 1080, 1'b0);

        drain_pipe();
        if (err_count == 0)
            $display("** world_to_screen_projector: PASSED **");
        else
            $display("** world_to_screen_projector: FAILED **");
        $finish;
    end
endmodule
